@@ design/adc_register_block_defines.svh @@
// assertion macros for the adc register block
`ifndef ADC_REGISTER_BLOCK_DEFINES_SVH
`define ADC_REGISTER_BLOCK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define ADC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("adc register block check failed");

// implication that checks a later cycle, disabled in reset
`define ADC_ASSERT_LATER(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> cons) \
    else $error("adc register block timing check failed");

`else

`define ADC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define ADC_ASSERT_LATER(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

@@ design/adc_rb_pkg.sv @@
// shared types and constants of the adc register block
package adc_rb_pkg;

  // number of converters fitted (1 to 3)
  localparam int NUM_CONV = 3;
  localparam int CONV_IDX_W = (NUM_CONV > 1) ? $clog2(NUM_CONV) : 1;

  // page select in address bits 9..8
  localparam logic [1:0] COMMON_PAGE = 2'd3;

  // converter page offsets
  localparam logic [7:0] OFS_STATUS = 8'h00;
  localparam logic [7:0] OFS_CTRL1  = 8'h04;
  localparam logic [7:0] OFS_CTRL2  = 8'h08;
  localparam logic [7:0] OFS_SEQ    = 8'h2C;
  localparam logic [7:0] OFS_DATA   = 8'h4C;

  // common page offsets
  localparam logic [7:0] OFS_CSTATUS = 8'h00;
  localparam logic [7:0] OFS_CCTRL   = 8'h04;

  // register bit positions
  localparam int BIT_START   = 5;
  localparam int BIT_EOC     = 1;
  localparam int BIT_SWSTART = 30;
  localparam int BIT_ALIGN   = 11;
  localparam int RES_LSB     = 24;

  // sample value, fixed at its reset value
  localparam logic [15:0] SAMPLE_RESET = 16'hFFFF;

  // transaction status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNMAPPED   = 2'd1,
    ST_RESOLUTION = 2'd2,
    ST_READ_ONLY  = 2'd3
  } status_t;

  // one bus access
  typedef struct packed {
    logic        op;
    logic [9:0]  address;
    logic [31:0] write_data;
  } acc_t;

  // one access result
  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
  } res_t;

endpackage

@@ design/adc_rb_capture.sv @@
// input register stage that captures an accepted bus access
module adc_rb_capture import adc_rb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  acc_t        acc_in,
  output logic        acc_valid,
  output acc_t        acc_q
);

  // valid flag, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else begin
      acc_valid <= accept;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_q <= acc_in;
    end
  end

endmodule

@@ design/adc_rb_regfile.sv @@
// converter and common registers with access decode and update
module adc_rb_regfile import adc_rb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic acc_valid,
  input  acc_t acc,
  output res_t res
);

  logic [31:0] conv_status      [NUM_CONV];
  logic [31:0] conv_control_one [NUM_CONV];
  logic [31:0] conv_control_two [NUM_CONV];
  logic [31:0] conv_sequence    [NUM_CONV];
  logic [31:0] common_control;

  logic [31:0] conv_status_next      [NUM_CONV];
  logic [31:0] conv_control_one_next [NUM_CONV];
  logic [31:0] conv_control_two_next [NUM_CONV];
  logic [31:0] conv_sequence_next    [NUM_CONV];
  logic [31:0] common_control_next;

  logic [1:0]            page;
  logic [7:0]            ofs;
  logic [CONV_IDX_W-1:0] sel;
  logic                  conv_hit;
  logic                  common_hit;
  logic [31:0]           merged;
  logic [31:0]           rd;
  status_t               st;

  assign page       = acc.address[9:8];
  assign ofs        = acc.address[7:0];
  assign sel        = page[CONV_IDX_W-1:0];
  assign conv_hit   = (page < 2'(NUM_CONV));
  assign common_hit = (page == COMMON_PAGE);

  // merged status word of all converters
  always_comb begin
    merged = '0;
    for (int k = 0; k < NUM_CONV; k++) begin
      merged = merged | 32'(conv_status[k] << (8 * k));
    end
  end

  // access decode, read mux and next register values
  always_comb begin
    conv_status_next      = conv_status;
    conv_control_one_next = conv_control_one;
    conv_control_two_next = conv_control_two;
    conv_sequence_next    = conv_sequence;
    common_control_next   = common_control;
    rd = '0;
    st = ST_OK;
    if (common_hit) begin
      unique case (ofs)
        OFS_CSTATUS: begin
          if (acc.op) st = ST_READ_ONLY;
          else rd = merged;
        end
        OFS_CCTRL: begin
          if (acc.op) common_control_next = acc.write_data;
          else rd = common_control;
        end
        default: st = ST_UNMAPPED;
      endcase
    end else if (conv_hit) begin
      if (acc.op) begin
        unique case (ofs)
          OFS_STATUS: conv_status_next[sel] = acc.write_data;
          OFS_CTRL1:  conv_control_one_next[sel] = acc.write_data;
          OFS_CTRL2: begin
            // software start raises start and end of conversion
            if (acc.write_data[BIT_SWSTART]) begin
              conv_status_next[sel][BIT_START] = 1'b1;
              conv_status_next[sel][BIT_EOC]   = 1'b1;
            end
            conv_control_two_next[sel] = acc.write_data;
            conv_control_two_next[sel][BIT_SWSTART] = 1'b0;
          end
          OFS_SEQ:  conv_sequence_next[sel] = acc.write_data;
          OFS_DATA: st = ST_READ_ONLY;
          default:  st = ST_UNMAPPED;
        endcase
      end else begin
        unique case (ofs)
          OFS_STATUS: rd = conv_status[sel];
          OFS_CTRL1:  rd = conv_control_one[sel];
          OFS_CTRL2:  rd = conv_control_two[sel];
          OFS_SEQ:    rd = conv_sequence[sel];
          OFS_DATA: begin
            // data read clears end of conversion even on a resolution error
            conv_status_next[sel][BIT_EOC] = 1'b0;
            if (conv_control_one[sel][RES_LSB+1:RES_LSB] != 2'b00) begin
              st = ST_RESOLUTION;
            end else if (conv_control_two[sel][BIT_ALIGN]) begin
              rd = {16'h0000, SAMPLE_RESET[11:0], 4'h0};
            end else begin
              rd = {20'h00000, SAMPLE_RESET[11:0]};
            end
          end
          default: st = ST_UNMAPPED;
        endcase
      end
    end else begin
      st = ST_UNMAPPED;
    end
    if (acc.op || st != ST_OK) rd = '0;
  end

  assign res.read_data = rd;
  assign res.status    = st;

  // register update on a valid transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CONV; k++) begin
        conv_status[k]      <= '0;
        conv_control_one[k] <= '0;
        conv_control_two[k] <= '0;
        conv_sequence[k]    <= '0;
      end
      common_control <= '0;
    end else if (acc_valid) begin
      conv_status      <= conv_status_next;
      conv_control_one <= conv_control_one_next;
      conv_control_two <= conv_control_two_next;
      conv_sequence    <= conv_sequence_next;
      common_control   <= common_control_next;
    end
  end

endmodule

@@ design/adc_register_block.sv @@
// adc register block: accepted access passes input and result registers to done
// one access accepted per cycle unless busy; busy is high in reset and the cycle after
// access decode and register update sit between the input and result registers
// synchronous active-high reset clears regfile, valid and done; sample holds 0xFFFF
// a result on read_data/status is marked by done and holds until the next result
`include "adc_register_block_defines.svh"

module adc_register_block import adc_rb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [9:0]  address,
  input  logic [31:0] write_data,
  output logic        done,
  output logic [31:0] read_data,
  output logic [1:0]  status
);

  logic accept;
  acc_t acc_in;
  acc_t acc_q;
  logic acc_valid;
  res_t res;

  assign accept            = start && !busy;
  assign acc_in.op         = op;
  assign acc_in.address    = address;
  assign acc_in.write_data = write_data;

  // busy while coming out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  adc_rb_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .acc_in    (acc_in),
    .acc_valid (acc_valid),
    .acc_q     (acc_q)
  );

  adc_rb_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .acc_valid (acc_valid),
    .acc       (acc_q),
    .res       (res)
  );

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_valid) begin
      read_data <= res.read_data;
      status    <= res.status;
    end
  end

  // checks
  `ADC_ASSERT_LATER(a_accept_done, clk, rst, accept, ##2 done)
  `ADC_ASSERT_NOW(a_done_had_accept, clk, rst, done, $past(accept, 2))
  `ADC_ASSERT_NOW(a_error_zero, clk, rst, done && status != ST_OK, read_data == 32'h0)

endmodule
